/* design/divstep_binary_gcd_assert.svh */
// ----------------------------------------------------------------------------
// divstep_binary_gcd assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef DIVSTEP_BINARY_GCD_ASSERT_SVH
`define DIVSTEP_BINARY_GCD_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define DBGCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbgcd: assertion failed");

// consequent checked in the cycle after the antecedent
`define DBGCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbgcd: assertion failed");

`endif

/* design/dbgcd_pkg.sv */
// ----------------------------------------------------------------------------
// dbgcd_pkg
// shared constants and controller/datapath command and status types
// ----------------------------------------------------------------------------
package dbgcd_pkg;

    localparam int FIELD_BITS        = 64;
    localparam int WORD_BITS_DEFAULT = 64;

    typedef struct packed {
        logic load;
        logic fold_a;
        logic fold_b;
        logic strip;
        logic order;
        logic step;
        logic fix;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic strip_done;
        logic g_zero;
    } status_t;

endpackage

/* design/dbgcd_if.sv */
// ----------------------------------------------------------------------------
// dbgcd channel interfaces
// valid/ready channels for operand pairs and gcd results
// ----------------------------------------------------------------------------
interface dbgcd_in_if;
    logic                              valid;
    logic                              ready;
    logic [dbgcd_pkg::FIELD_BITS-1:0]  a;
    logic [dbgcd_pkg::FIELD_BITS-1:0]  b;

    modport source (output valid, output a, output b, input ready);
    modport sink   (input valid, input a, input b, output ready);
endinterface

interface dbgcd_out_if;
    logic                              valid;
    logic                              ready;
    logic [dbgcd_pkg::FIELD_BITS-1:0]  divisor;

    modport source (output valid, output divisor, input ready);
    modport sink   (input valid, input divisor, output ready);
endinterface

/* design/dbgcd_dpath.sv */
// ----------------------------------------------------------------------------
// dbgcd_dpath
// operand registers, trailing-zero strip, divstep unit and result register
// ----------------------------------------------------------------------------
module dbgcd_dpath #(
    parameter int WORD_BITS = dbgcd_pkg::WORD_BITS_DEFAULT
) (
    input  logic                             clk,
    input  dbgcd_pkg::cmd_t                  cmd,
    input  logic [dbgcd_pkg::FIELD_BITS-1:0] a_in,
    input  logic [dbgcd_pkg::FIELD_BITS-1:0] b_in,
    output dbgcd_pkg::status_t               status,
    output logic [dbgcd_pkg::FIELD_BITS-1:0] divisor
);

    localparam int EXP_BITS   = $clog2(WORD_BITS);
    localparam int DELTA_BITS = $clog2(4 * WORD_BITS) + 2;
    localparam logic [WORD_BITS-1:0] TOP_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [DELTA_BITS-1:0] DELTA_ONE = DELTA_BITS'(1);

    logic [WORD_BITS-1:0]          ma_reg;
    logic [WORD_BITS-1:0]          mb_reg;
    logic [EXP_BITS-1:0]           e_reg;
    logic signed [WORD_BITS:0]     fa_reg;
    logic signed [WORD_BITS:0]     gb_reg;
    logic signed [DELTA_BITS-1:0]  delta_reg;
    logic [WORD_BITS-1:0]          res_reg;
    logic [dbgcd_pkg::FIELD_BITS-1:0] divisor_reg;

    logic                          a_shift;
    logic                          b_shift;
    logic                          g_odd;
    logic                          d_pos;
    logic                          swap;
    logic signed [WORD_BITS:0]     addend;
    logic signed [WORD_BITS:0]     step_sum;
    logic [WORD_BITS:0]            abs_fa;
    logic [WORD_BITS-1:0]          shifted;

    // magnitude of the low word, sign extended; the most negative gives the top bit
    function automatic logic [WORD_BITS-1:0] mag_of(
        input logic [dbgcd_pkg::FIELD_BITS-1:0] raw
    );
        logic [WORD_BITS-1:0] low;
        low = raw[WORD_BITS-1:0];
        return low[WORD_BITS-1] ? (~low + 1'b1) : low;
    endfunction

    assign a_shift = !ma_reg[0] && (ma_reg != '0);
    assign b_shift = !mb_reg[0] && (mb_reg != '0);

    assign g_odd = gb_reg[0];
    assign d_pos = !delta_reg[DELTA_BITS-1] && (delta_reg != '0);
    assign swap  = g_odd && d_pos;

    // one adder: g - f on a swap, g + f otherwise; sum is even when g is odd
    assign addend   = swap ? ~fa_reg : fa_reg;
    assign step_sum = gb_reg + addend + (WORD_BITS+1)'(swap);

    assign abs_fa  = fa_reg[WORD_BITS] ? (~fa_reg + 1'b1) : fa_reg;
    assign shifted = res_reg << e_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ma_reg <= mag_of(a_in);
            mb_reg <= mag_of(b_in);
            e_reg  <= '0;
        end
        else if (cmd.fold_a)
        begin
            if (ma_reg == TOP_BIT)
            begin
                ma_reg <= TOP_BIT - mb_reg;
            end
        end
        else if (cmd.fold_b)
        begin
            if (mb_reg == TOP_BIT)
            begin
                mb_reg <= TOP_BIT - ma_reg;
            end
        end
        else if (cmd.strip)
        begin
            if (a_shift)
            begin
                ma_reg <= ma_reg >> 1;
            end
            if (b_shift)
            begin
                mb_reg <= mb_reg >> 1;
            end
            // a zero operand counts as even, so e ends at the smaller count
            if (!ma_reg[0] && !mb_reg[0])
            begin
                e_reg <= e_reg + 1'b1;
            end
        end

        if (cmd.order)
        begin
            delta_reg <= DELTA_ONE;
            if (ma_reg >= mb_reg)
            begin
                fa_reg <= {1'b0, ma_reg};
                gb_reg <= {1'b0, mb_reg};
            end
            else
            begin
                fa_reg <= {1'b0, mb_reg};
                gb_reg <= {1'b0, ma_reg};
            end
        end
        else if (cmd.step)
        begin
            gb_reg <= g_odd ? (step_sum >>> 1) : (gb_reg >>> 1);
            if (swap)
            begin
                fa_reg    <= gb_reg;
                delta_reg <= DELTA_ONE - delta_reg;
            end
            else
            begin
                delta_reg <= delta_reg + DELTA_ONE;
            end
        end

        if (cmd.fix)
        begin
            res_reg <= abs_fa[WORD_BITS-1:0];
        end

        if (cmd.emit)
        begin
            divisor_reg <= dbgcd_pkg::FIELD_BITS'(shifted);
        end
    end

    assign status.strip_done = !a_shift && !b_shift;
    assign status.g_zero     = (gb_reg == '0);
    assign divisor           = divisor_reg;

endmodule

/* design/dbgcd_ctrl.sv */
// ----------------------------------------------------------------------------
// dbgcd_ctrl
// sequencer for setup, divstep loop and result handoff
// ----------------------------------------------------------------------------
module dbgcd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  dbgcd_pkg::status_t status,
    output dbgcd_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD_A,
        ST_FOLD_B,
        ST_STRIP,
        ST_ORDER,
        ST_STEP,
        ST_FIX,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   emit_ok;

    // output register is free when empty or being drained this cycle
    assign emit_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.load   = (state_reg == ST_IDLE) && in_valid;
        cmd.fold_a = (state_reg == ST_FOLD_A);
        cmd.fold_b = (state_reg == ST_FOLD_B);
        cmd.strip  = (state_reg == ST_STRIP) && !status.strip_done;
        cmd.order  = (state_reg == ST_ORDER);
        cmd.step   = (state_reg == ST_STEP) && !status.g_zero;
        cmd.fix    = (state_reg == ST_FIX);
        cmd.emit   = (state_reg == ST_EMIT) && emit_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_FOLD_A;
                    end
                end
                ST_FOLD_A: state_reg <= ST_FOLD_B;
                ST_FOLD_B: state_reg <= ST_STRIP;
                ST_STRIP:
                begin
                    if (status.strip_done)
                    begin
                        state_reg <= ST_ORDER;
                    end
                end
                ST_ORDER: state_reg <= ST_STEP;
                ST_STEP:
                begin
                    if (status.g_zero)
                    begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX: state_reg <= ST_EMIT;
                ST_EMIT:
                begin
                    if (emit_ok)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            if ((state_reg == ST_EMIT) && emit_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* design/divstep_binary_gcd.sv */
// ----------------------------------------------------------------------------
// divstep_binary_gcd
// gcd of two signed words by divsteps, one divstep per clock
// ----------------------------------------------------------------------------
//  channel | dir | fields            | transaction
//  req     | in  | a, b (signed)     | req.valid && req.ready
//  rsp     | out | divisor (unsigned)| rsp.valid && rsp.ready
//
// one operand pair at a time: after accept the sequencer runs fold a, fold b, strip
// (one right shift a cycle on each nonzero even magnitude), order, the divsteps
// (one per cycle, until g is zero), fix, then emit once the output register is free
// async active-low reset clears the sequencer and the output valid; no clearing pass
// a result waits in the output register while the next pair is taken;
// a second result waits in the sequencer until the first one is taken
module divstep_binary_gcd #(
    parameter int WORD_BITS = dbgcd_pkg::WORD_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    dbgcd_in_if.sink    req,
    dbgcd_out_if.source rsp
);

    dbgcd_pkg::cmd_t    cmd;
    dbgcd_pkg::status_t status;

    dbgcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    dbgcd_dpath #(
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .clk     (clk),
        .cmd     (cmd),
        .a_in    (req.a),
        .b_in    (req.b),
        .status  (status),
        .divisor (rsp.divisor)
    );

endmodule

/* design/dbgcd_checker.sv */
// ----------------------------------------------------------------------------
// dbgcd_checker
// port-level checks on the gcd block, bound to the top level
// ----------------------------------------------------------------------------
`include "divstep_binary_gcd_assert.svh"

module dbgcd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [dbgcd_pkg::FIELD_BITS-1:0] rsp_divisor
);

    // stalled result stays offered
    `DBGCD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

    // stalled result keeps its value
    `DBGCD_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_divisor))

    // one pair at a time: busy right after a transaction on req
    `DBGCD_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

    // a new result appears as the sequencer returns to idle
    `DBGCD_ASSERT_NOW(a_idle_on_result, $rose(rsp_valid), req_ready)

    // the largest gcd is the top-bit-only pattern
    `DBGCD_ASSERT_NOW(a_top_only, rsp_valid && rsp_divisor[63], rsp_divisor[62:0] == '0)

endmodule

bind divstep_binary_gcd dbgcd_checker u_dbgcd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_divisor (rsp.divisor)
);
